FILE: hw/rtl/d2md_pkg.sv
// Shared types and constants for the disparity-to-depth pipeline.
// No dependencies; imported by every module of the block.
package d2md_pkg;

  // Widths of the external fields
  localparam int unsigned DataW   = 32;
  localparam int unsigned RayW    = 24;
  localparam int unsigned CfgIdxW = 3;

  // Quotient bits resolved by the divider chain (depth is 31 bits plus sign)
  localparam int unsigned QBits   = 31;
  // Numerator: depth_scale shifted up 16 plus half the gap
  localparam int unsigned NumW    = DataW + 16 + 1;
  // Slope times ray weight
  localparam int unsigned ProdW   = 31 + RayW;

  localparam logic [DataW-1:0] DepthMax = 32'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFloorSlope = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFloorShift = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFloorTol   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDepthScale = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinGap     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvDepth   = 3'd5;

  // Configuration values seen by the front end
  typedef struct packed {
    logic [30:0]      floor_slope;
    logic [DataW-1:0] floor_shift;
    logic [30:0]      floor_tolerance;
    logic [DataW-1:0] depth_scale;
    logic [30:0]      min_gap;
  } cfg_t;

  // Item state handed from cell to cell
  typedef struct packed {
    logic             vld;   // stage holds an item
    logic             ok;    // pixel passed all tests
    logic             sat;   // quotient clamps
    logic [DataW-1:0] gap;   // divisor
    logic [DataW-1:0] rem;   // partial remainder
    logic [QBits-1:0] lo;    // numerator bits not yet shifted in
    logic [QBits-1:0] quo;   // quotient bits so far
  } cell_t;

endpackage

FILE: hw/rtl/d2md_front.sv
// Front end: gap, floor-line product, pixel tests and numerator setup.
// Two register stages; depends on d2md_pkg.
module d2md_front
  import d2md_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             adv_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] disparity_i,
  input  logic             disparity_finite_i,
  input  logic [RayW-1:0]  floor_ray_i,
  output cell_t            cell_o
);

  // Stage A registers
  logic             a_vld_q, a_vld_d;
  logic             a_fin_q;
  logic             a_raynz_q;
  logic [32:0]      a_gap_q, a_gap_d;
  logic [33:0]      a_t_q, a_t_d;
  logic [ProdW-1:0] a_prod_q;

  // Stage B register
  cell_t b_q, b_d;

  logic             a_load;
  logic             beyond;
  logic             gap_pos;
  logic [NumW-1:0]  num;
  logic [ProdW-1:0] t_scaled;

  // Stage A loads when empty or when it moves on
  assign a_load     = adv_i || !a_vld_q;
  assign in_ready_o = a_load;

  // Form gap and gap plus tolerance at full width
  always_comb begin
    a_gap_d = {disparity_i[DataW-1], disparity_i}
            - {cfg_i.floor_shift[DataW-1], cfg_i.floor_shift};
    a_t_d   = {a_gap_d[32], a_gap_d} + {3'b000, cfg_i.floor_tolerance};
    a_vld_d = a_load ? in_valid_i : a_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_fin_q   <= disparity_finite_i;
      a_raynz_q <= (floor_ray_i != '0);
      a_gap_q   <= a_gap_d;
      a_t_q     <= a_t_d;
      a_prod_q  <= cfg_i.floor_slope * floor_ray_i;
    end
  end

  // Floor test: below the line when the ray is nonzero and (gap + tol) * 2^16 < slope * ray
  always_comb begin
    t_scaled = {6'b0, a_t_q[32:0], 16'b0};
    beyond   = a_raynz_q && (a_t_q[33] || (t_scaled < a_prod_q));
    gap_pos  = !a_gap_q[32] && (a_gap_q[31:0] != '0);
    num      = {1'b0, cfg_i.depth_scale, 16'b0} + {18'b0, a_gap_q[31:1]};

    b_d     = b_q;
    b_d.vld = a_vld_q;
    b_d.ok  = a_fin_q && gap_pos && !beyond
           && (a_gap_q[31:0] >= {1'b0, cfg_i.min_gap});
    b_d.gap = a_gap_q[31:0];
    // Quotient reaches 2^31 when the top numerator bits reach the divisor
    b_d.sat = ({14'b0, num[NumW-1:QBits]} >= a_gap_q[31:0]);
    b_d.rem = {14'b0, num[NumW-1:QBits]};
    b_d.lo  = num[QBits-1:0];
    b_d.quo = '0;
  end

  // Advance stage B with the rest of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (adv_i) begin
      b_q <= b_d;
    end
  end

  assign cell_o = b_q;

endmodule

FILE: hw/rtl/d2md_div_cell.sv
// One restoring-division cell: resolves one quotient bit per item.
// Depends on d2md_pkg for the cell_t hand-off type.
module d2md_div_cell
  import d2md_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t      cell_q, cell_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    trial  = {cell_i.rem, cell_i.lo[QBits-1]};
    diff   = trial - {1'b0, cell_i.gap};
    take   = (trial >= {1'b0, cell_i.gap});
    cell_d = cell_i;
    cell_d.rem = take ? diff[31:0] : trial[31:0];
    cell_d.lo  = {cell_i.lo[QBits-2:0], 1'b0};
    cell_d.quo = {cell_i.quo[QBits-2:0], take};
  end

  // Hand the item to the next cell when the pipeline advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: hw/rtl/disparity_to_metric_depth_top.sv
// Top level: configuration registers, front end, divider cell chain, output register.
// Depends on d2md_pkg, d2md_front and d2md_div_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid_i/in_ready_o| disparity_i, disparity_finite_i, floor_ray_i
//  output   | out_valid_o/out_ready_i | depth_o, depth_valid_o, depth_saturated_o
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One pixel per clock while the output is taken; the path holds two front-end stages,
// 31 divider cells (one quotient bit each) and the output register.
// The whole pipeline advances together when the output register is free or taken;
// the first stage still accepts a pixel while stalled if it is empty.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module disparity_to_metric_depth_top
  import d2md_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DataW-1:0]   disparity_i,
  input  logic               disparity_finite_i,
  input  logic [RayW-1:0]    floor_ray_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   depth_o,
  output logic               depth_valid_o,
  output logic               depth_saturated_o
);

  cfg_t             cfg_q;
  logic [DataW-1:0] inv_depth_q;
  logic             adv;

  cell_t            chain [QBits+1];

  logic             out_vld_q;
  logic [DataW-1:0] depth_q, depth_d;
  logic             dvalid_q;
  logic             dsat_q;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_slope     <= 31'd65536;
      cfg_q.floor_shift     <= '0;
      cfg_q.floor_tolerance <= '0;
      cfg_q.depth_scale     <= 32'd65536;
      cfg_q.min_gap         <= '0;
      inv_depth_q           <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFloorSlope: cfg_q.floor_slope     <= cfg_data_i[30:0];
        RegFloorShift: cfg_q.floor_shift     <= cfg_data_i;
        RegFloorTol:   cfg_q.floor_tolerance <= cfg_data_i[30:0];
        RegDepthScale: cfg_q.depth_scale     <= cfg_data_i;
        RegMinGap:     cfg_q.min_gap         <= cfg_data_i[30:0];
        RegInvDepth:   inv_depth_q           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the pipeline when the output register is free or being taken
  assign adv = !out_vld_q || out_ready_i;

  d2md_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .adv_i              (adv),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .disparity_i        (disparity_i),
    .disparity_finite_i (disparity_finite_i),
    .floor_ray_i        (floor_ray_i),
    .cell_o             (chain[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < QBits; k++) begin : g_cell
    d2md_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // Select the reported depth
  always_comb begin
    if (!chain[QBits].ok) begin
      depth_d = inv_depth_q;
    end else if (chain[QBits].sat) begin
      depth_d = DepthMax;
    end else begin
      depth_d = {1'b0, chain[QBits].quo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= chain[QBits].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      depth_q  <= depth_d;
      dvalid_q <= chain[QBits].ok;
      dsat_q   <= chain[QBits].ok && chain[QBits].sat;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign depth_o           = depth_q;
  assign depth_valid_o     = dvalid_q;
  assign depth_saturated_o = dsat_q;

endmodule

FILE: hw/rtl/d2md_checker.sv
// Port-level checks for the disparity-to-depth block, bound to the top level.
// Depends on d2md_pkg for widths and the clamp value.
module d2md_checker
  import d2md_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] depth_o,
  input logic             depth_valid_o,
  input logic             depth_saturated_o
);

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(depth_o))
    else $error("stalled result changed");

  // Input side only stalls when a result is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Clamped results carry the clamp value and are valid
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_saturated_o |-> depth_valid_o && (depth_o == DepthMax))
    else $error("saturated depth wrong");

  // Computed depth is never negative
  a_depth_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_valid_o |-> !depth_o[DataW-1])
    else $error("negative computed depth");

  // Nothing leaves the block in the first cycle after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind disparity_to_metric_depth_top d2md_checker u_d2md_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .depth_o           (depth_o),
  .depth_valid_o     (depth_valid_o),
  .depth_saturated_o (depth_saturated_o)
);
